// ----- src/bst_pkg.sv -----
// shared types, character codes and limits of the bencode stream tokenizer
`default_nettype none

package bst_pkg;

    localparam int BST_MAX_DEPTH = 16;
    localparam int BST_LEN_BITS  = 32;

    // depth compare width, enough for depth parameters up to 255
    localparam int DEPTH_CMP_W = 8;

    localparam logic [4:0] DEPTH_LIMIT_RESET = 5'd16;

    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6c;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // signed 64-bit magnitude limits split as limit = 10 * quotient + remainder
    localparam logic [63:0] INT_QUOT    = 64'd922337203685477580;
    localparam logic [3:0]  INT_REM_POS = 4'd7;
    localparam logic [3:0]  INT_REM_NEG = 4'd8;

    localparam logic [3:0] KEY_FULL = 4'd4;
    localparam logic [3:0] KEY_DEAD = 4'd8;

    typedef enum logic [3:0] {
        EV_BUSY       = 4'd0,
        EV_INT_DONE   = 4'd1,
        EV_STR_HEADER = 4'd2,
        EV_STR_BYTE   = 4'd3,
        EV_STR_DONE   = 4'd4,
        EV_LIST_OPEN  = 4'd5,
        EV_DICT_OPEN  = 4'd6,
        EV_CLOSE      = 4'd7,
        EV_TOP_DONE   = 4'd8,
        EV_ERROR      = 4'd9
    } t_event;

    typedef struct packed {
        t_event             event_res;
        logic signed [63:0] token_value;
        logic [4:0]         nest_depth;
        logic [31:0]        byte_offset;
        logic               info_key;
        logic [31:0]        info_offset;
    } t_result;

    function automatic logic [7:0] info_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h69;
            2'd1:    c = 8'h6e;
            2'd2:    c = 8'h66;
            default: c = 8'h6f;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/bst_if.sv -----
// valid/ready channel interfaces for the byte input, event output and config write
`default_nettype none

interface bst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface bst_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         event_res;
    logic signed [63:0] token_value;
    logic [4:0]         nest_depth;
    logic [31:0]        byte_offset;
    logic               info_key;
    logic [31:0]        info_offset;

    modport source (output valid, output event_res, output token_value, output nest_depth,
                    output byte_offset, output info_key, output info_offset, input ready);
    modport sink   (input valid, input event_res, input token_value, input nest_depth,
                    input byte_offset, input info_key, input info_offset, output ready);
endinterface

interface bst_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] depth_limit;

    modport source (output valid, output depth_limit, input ready);
    modport sink   (input valid, input depth_limit, output ready);
endinterface

`default_nettype wire

// ----- src/bst_digit.sv -----
// decimal digit accumulate with overflow check against a split limit
`default_nettype none

module bst_digit import bst_pkg::*; (
    input  wire logic [63:0] i_acc,
    input  wire logic [3:0]  i_digit,
    input  wire logic [63:0] i_quot,
    input  wire logic [3:0]  i_rem,
    output logic      [63:0] o_sum,
    output logic             o_ovf
);

    // acc * 10 + digit as shift and add
    assign o_sum = {i_acc[60:0], 3'b000} + {i_acc[62:0], 1'b0} + {60'd0, i_digit};

    // acc * 10 + digit > quot * 10 + rem
    assign o_ovf = (i_acc > i_quot) || ((i_acc == i_quot) && (i_digit > i_rem));

endmodule

`default_nettype wire

// ----- src/bst_core.sv -----
// parse state registers and the per-byte mode update
`default_nettype none

module bst_core import bst_pkg::*; #(
    parameter int MAX_DEPTH = BST_MAX_DEPTH,
    parameter int LEN_BITS  = BST_LEN_BITS
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_byte,
    input  wire logic [4:0] i_depth_limit,
    output t_result         o_res
);

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam logic [63:0] LEN_LIM  = (64'd1 << LEN_BITS) - 64'd1;
    localparam logic [63:0] LEN_QUOT = LEN_LIM / 10;
    localparam logic [3:0]  LEN_REM  = 4'(LEN_LIM % 10);
    localparam logic [DEPTH_CMP_W-1:0] MAX_DEPTH_C = DEPTH_CMP_W'(MAX_DEPTH);

    typedef enum logic [5:0] {
        M_EXPECT     = 6'b000001,
        M_INT_START  = 6'b000010,
        M_INT_SIGN   = 6'b000100,
        M_INT_DIGITS = 6'b001000,
        M_STR_LEN    = 6'b010000,
        M_STR_BODY   = 6'b100000
    } t_mode;

    t_mode               r_mode,   n_mode;
    logic [DEPTH_W-1:0]  r_depth,  n_depth;
    logic [63:0]         r_acc,    n_acc;
    logic                r_neg,    n_neg;
    logic [LEN_BITS-1:0] r_left,   n_left;
    logic [3:0]          r_key,    n_key;
    logic [31:0]         r_offset;
    logic [31:0]         r_info,   n_info;
    logic                r_err,    n_err;

    logic                   is_digit;
    logic [3:0]             digit;
    logic [63:0]            quot;
    logic [3:0]             rem;
    logic [63:0]            acc_sum;
    logic                   acc_ovf;
    logic [LEN_BITS-1:0]    left_dec;
    logic [DEPTH_CMP_W-1:0] limit;
    logic [DEPTH_CMP_W-1:0] depth_ext;
    logic                   bad;
    t_event                 ev;
    logic signed [63:0]     val;
    logic                   ikey;

    assign is_digit  = i_byte inside {[CH_ZERO:CH_NINE]};
    assign digit     = 4'(i_byte - CH_ZERO);
    assign left_dec  = r_left - LEN_BITS'(1);
    assign depth_ext = DEPTH_CMP_W'(r_depth);
    assign limit     = (DEPTH_CMP_W'(i_depth_limit) < MAX_DEPTH_C) ?
                       DEPTH_CMP_W'(i_depth_limit) : MAX_DEPTH_C;

    // integer limit while in digits, length limit otherwise
    assign quot = (r_mode == M_INT_DIGITS) ? INT_QUOT : LEN_QUOT;
    assign rem  = (r_mode == M_INT_DIGITS) ? (r_neg ? INT_REM_NEG : INT_REM_POS) : LEN_REM;

    bst_digit u_digit (
        .i_acc   (r_acc),
        .i_digit (digit),
        .i_quot  (quot),
        .i_rem   (rem),
        .o_sum   (acc_sum),
        .o_ovf   (acc_ovf)
    );

    always_comb begin
        n_mode  = r_mode;
        n_depth = r_depth;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_left  = r_left;
        n_key   = r_key;
        n_info  = r_info;
        bad     = 1'b0;
        ev      = EV_BUSY;
        val     = '0;
        ikey    = 1'b0;
        if (!r_err) begin
            case (r_mode)
                M_EXPECT: begin
                    if (i_byte == CH_I) begin
                        n_mode = M_INT_START;
                        n_acc  = '0;
                        n_neg  = 1'b0;
                    end else if (i_byte == CH_L || i_byte == CH_D) begin
                        if (depth_ext >= limit) begin
                            bad = 1'b1;
                        end else begin
                            n_depth = r_depth + DEPTH_W'(1);
                            ev      = (i_byte == CH_L) ? EV_LIST_OPEN : EV_DICT_OPEN;
                        end
                    end else if (i_byte == CH_E) begin
                        if (r_depth == '0) begin
                            bad = 1'b1;
                        end else begin
                            n_depth = r_depth - DEPTH_W'(1);
                            ev      = (r_depth == DEPTH_W'(1)) ? EV_TOP_DONE : EV_CLOSE;
                        end
                    end else if (is_digit) begin
                        n_acc  = {60'd0, digit};
                        n_mode = M_STR_LEN;
                    end else begin
                        bad = 1'b1;
                    end
                end
                M_INT_START: begin
                    if (i_byte == CH_MINUS) begin
                        n_neg  = 1'b1;
                        n_mode = M_INT_SIGN;
                    end else if (is_digit) begin
                        n_acc  = {60'd0, digit};
                        n_mode = M_INT_DIGITS;
                    end else begin
                        bad = 1'b1;
                    end
                end
                M_INT_SIGN: begin
                    if (is_digit) begin
                        n_acc  = {60'd0, digit};
                        n_mode = M_INT_DIGITS;
                    end else begin
                        bad = 1'b1;
                    end
                end
                M_INT_DIGITS: begin
                    if (is_digit) begin
                        if (acc_ovf) begin
                            bad = 1'b1;
                        end else begin
                            n_acc = acc_sum;
                        end
                    end else if (i_byte == CH_E) begin
                        ev     = EV_INT_DONE;
                        val    = r_neg ? (64'd0 - r_acc) : r_acc;
                        n_mode = M_EXPECT;
                    end else begin
                        bad = 1'b1;
                    end
                end
                M_STR_LEN: begin
                    if (is_digit) begin
                        if (acc_ovf) begin
                            bad = 1'b1;
                        end else begin
                            n_acc = acc_sum;
                        end
                    end else if (i_byte == CH_COLON) begin
                        n_key  = '0;
                        n_left = r_acc[LEN_BITS-1:0];
                        if (r_acc == '0) begin
                            ev     = EV_STR_DONE;
                            n_mode = M_EXPECT;
                        end else begin
                            ev     = EV_STR_HEADER;
                            val    = r_acc;
                            n_mode = M_STR_BODY;
                        end
                    end else begin
                        bad = 1'b1;
                    end
                end
                M_STR_BODY: begin
                    if (r_key < KEY_FULL && i_byte == info_char(r_key[1:0])) begin
                        n_key = r_key + 4'd1;
                    end else begin
                        n_key = KEY_DEAD;
                    end
                    n_left = left_dec;
                    if (left_dec == '0) begin
                        ev = EV_STR_DONE;
                        if (n_key == KEY_FULL) begin
                            ikey   = 1'b1;
                            n_info = r_offset - 32'd3;
                        end
                        n_mode = M_EXPECT;
                    end else begin
                        ev = EV_STR_BYTE;
                    end
                end
                default: begin
                    n_mode = M_EXPECT;
                end
            endcase
        end
        n_err = r_err | bad;
        if (n_err) begin
            ev   = EV_ERROR;
            val  = '0;
            ikey = 1'b0;
        end
    end

    always_comb begin
        o_res.event_res   = ev;
        o_res.token_value = val;
        o_res.nest_depth  = 5'(n_depth);
        o_res.byte_offset = r_offset;
        o_res.info_key    = ikey;
        o_res.info_offset = n_info;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_EXPECT;
            r_depth  <= '0;
            r_acc    <= '0;
            r_neg    <= 1'b0;
            r_left   <= '0;
            r_key    <= '0;
            r_offset <= '0;
            r_info   <= '0;
            r_err    <= 1'b0;
        end else if (i_fire) begin
            r_mode   <= n_mode;
            r_depth  <= n_depth;
            r_acc    <= n_acc;
            r_neg    <= n_neg;
            r_left   <= n_left;
            r_key    <= n_key;
            r_offset <= r_offset + 32'd1;
            r_info   <= n_info;
            r_err    <= n_err;
        end
    end

endmodule

`default_nettype wire

// ----- src/bencode_stream_tokenizer.sv -----
// top level of the bencode stream tokenizer: config register, parse core, output register
`default_nettype none

// Streaming bencode tokenizer. Each byte transaction on i_in yields exactly one event
// transaction on o_out, in the next cycle through the output register; a new byte is taken
// every cycle as long as the output register is empty or being drained in the same cycle,
// so the sustained rate is one byte per clock. That figure is set by the mode
// update in the parse core, whose longest path is the 64-bit times-ten accumulate and its
// limit compare. Lists and dictionaries share one depth counter since both close on 'e';
// the limit in use is the smaller of depth_limit and MAX_DEPTH. Any malformed byte, a stray
// close, too deep nesting or a numeric overflow puts the block into a sticky error that only
// reset clears; after that every byte reports the error event while byte_offset keeps
// counting. depth_limit is written through i_cfg and should be changed only while idle.
// There is no clearing pass after reset.
module bencode_stream_tokenizer import bst_pkg::*; #(
    parameter int MAX_DEPTH = BST_MAX_DEPTH,
    parameter int LEN_BITS  = BST_LEN_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bst_cfg_if.sink    i_cfg,
    bst_in_if.sink     i_in,
    bst_out_if.source  o_out
);

    logic [4:0] r_depth_limit;   // configured nesting limit
    logic       r_valid;         // output register holds an event
    t_result    r_res;           // output register payload
    t_result    res;             // event for the byte taken this cycle
    logic       fire;            // byte transaction this cycle

    // config writes always land at once
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_limit <= DEPTH_LIMIT_RESET;
        end else if (i_cfg.valid) begin
            r_depth_limit <= i_cfg.depth_limit;
        end
    end

    // take a byte whenever the output register is free or drains this cycle
    assign i_in.ready = !r_valid || o_out.ready;
    assign fire       = i_in.valid && i_in.ready;

    bst_core #(
        .MAX_DEPTH (MAX_DEPTH),
        .LEN_BITS  (LEN_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_byte        (i_in.in_byte),
        .i_depth_limit (r_depth_limit),
        .o_res         (res)
    );

    // output register: valid is control, the payload needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (fire) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= res;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.event_res   = r_res.event_res;
    assign o_out.token_value = r_res.token_value;
    assign o_out.nest_depth  = r_res.nest_depth;
    assign o_out.byte_offset = r_res.byte_offset;
    assign o_out.info_key    = r_res.info_key;
    assign o_out.info_offset = r_res.info_offset;

endmodule

`default_nettype wire

// ----- src/bst_checker.sv -----
// port-level checks of the tokenizer and their bind to the top level
`default_nettype none

module bst_checker import bst_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [3:0]  i_event_res,
    input wire logic [63:0] i_token_value,
    input wire logic [31:0] i_byte_offset,
    input wire logic        i_info_key
);

    logic        r_seen;
    logic [31:0] r_last_off;
    logic        r_err;
    logic        out_fire;

    assign out_fire = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= 1'b0;
            r_last_off <= '0;
            r_err      <= 1'b0;
        end else if (out_fire) begin
            r_seen     <= 1'b1;
            r_last_off <= i_byte_offset;
            r_err      <= r_err || (i_event_res == EV_ERROR);
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("event dropped while stalled");

    a_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && r_seen |-> i_byte_offset == r_last_off + 32'd1)
        else $error("byte offsets of successive events not consecutive");

    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && r_err |-> i_event_res == EV_ERROR)
        else $error("error state left without reset");

    a_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_info_key || i_token_value != 64'd0) |->
        (i_info_key && i_event_res == EV_STR_DONE && i_token_value == 64'd0) ||
        (!i_info_key && (i_event_res == EV_INT_DONE || i_event_res == EV_STR_HEADER)))
        else $error("value or info flag on the wrong event");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output register");

endmodule

bind bencode_stream_tokenizer bst_checker u_bst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_event_res   (o_out.event_res),
    .i_token_value (o_out.token_value),
    .i_byte_offset (o_out.byte_offset),
    .i_info_key    (o_out.info_key)
);

`default_nettype wire
